### src/sdcm_pkg.sv
package sdcm_pkg;

    localparam int N_BITS = 17669;
    localparam int WORDS = 277;
    localparam int WORD_W = 64;
    localparam int IDX_W = 9;
    localparam int OP_W = 2;
    localparam int STEP_SHIFT = 6;
    localparam int POS_W = $clog2(WORDS * WORD_W);
    localparam int RING_W = WORDS * WORD_W;
    localparam int TOP_BITS = N_BITS % WORD_W;
    localparam logic [WORD_W-1:0] TOP_MASK =
        (TOP_BITS == 0) ? {WORD_W{1'b1}} : ((WORD_W'(1) << TOP_BITS) - WORD_W'(1));
    localparam logic [POS_W-1:0] TOP_POS = POS_W'(WORD_W * (WORDS - 1));
    localparam logic [POS_W-1:0] RING_LEN = POS_W'(N_BITS);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_ACC   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        logic clr;
        logic coarse;
        logic fine;
        logic xor_en;
    } t_cell_ctl;

endpackage

### src/sdcm_cell.sv
module sdcm_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sdcm_pkg::t_cell_ctl              i_ctl,
    input  logic                             i_load,
    input  logic [sdcm_pkg::WORD_W-1:0]      i_load_word,
    input  logic [sdcm_pkg::WORD_W-1:0]      i_coarse_word,
    input  logic [sdcm_pkg::WORD_W-1:0]      i_fine_word,
    output logic [sdcm_pkg::WORD_W-1:0]      o_acc
);

    logic [sdcm_pkg::WORD_W-1:0] r_acc;
    logic [sdcm_pkg::WORD_W-1:0] n_acc;
    logic [sdcm_pkg::WORD_W-1:0] r_dense;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.coarse) begin
            n_acc = i_coarse_word;
        end else if (i_ctl.fine) begin
            n_acc = i_fine_word;
        end else if (i_ctl.xor_en) begin
            n_acc = r_acc ^ r_dense;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dense <= i_load_word;
        end
    end

    assign o_acc = r_acc;

endmodule

### src/sparse_dense_cyclic_gf2_mul.sv
// Channel | Signals                                       | Transfer when
// input   | i_op, i_word_index, i_data_word               | start && !busy
// result  | o_result_word                                 | o_valid (one cycle)
//
// Load and clear complete in the accept cycle, as do an accumulate or a read whose word
// index is out of range. An accumulate scans the sparse bits up to the highest set bit; for
// each set bit inside the polynomial it turns the ring there and XORs in the dense store. A
// read turns the ring to the word and shows it. The ring turns from its last position one
// word or one bit per cycle. Reset zeros the accumulator; the dense store holds garbage
// until loaded. The receiver cannot stall: each result is shown for exactly one cycle.
module sparse_dense_cyclic_gf2_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sdcm_pkg::OP_W-1:0]         i_op,
    input  logic [sdcm_pkg::IDX_W-1:0]        i_word_index,
    input  logic [sdcm_pkg::WORD_W-1:0]       i_data_word,
    output logic                              o_valid,
    output logic [sdcm_pkg::WORD_W-1:0]       o_result_word
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_AIM  = 4'b0100,
        ST_MOVE = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    sdcm_pkg::t_op                   r_op, n_op;
    logic [sdcm_pkg::WORD_W-1:0]     r_data, n_data;
    logic [sdcm_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [sdcm_pkg::POS_W-1:0]      r_off, n_off;
    logic [sdcm_pkg::POS_W-1:0]      r_rem, n_rem;
    logic                            r_valid, n_valid;
    logic [sdcm_pkg::WORD_W-1:0]     r_result, n_result;

    sdcm_pkg::t_cell_ctl             w_ctl;
    sdcm_pkg::t_op                   w_in_op;
    logic                            w_accept;
    logic                            w_in_range;
    logic                            w_load_en;
    logic [sdcm_pkg::WORD_W-1:0]     w_load_word;
    logic [sdcm_pkg::POS_W:0]        w_wrap_dist;

    logic [sdcm_pkg::WORD_W-1:0]     w_acc   [sdcm_pkg::WORDS];
    logic [sdcm_pkg::RING_W-1:0]     w_flat;
    logic [sdcm_pkg::N_BITS-1:0]     w_ring;
    logic [sdcm_pkg::N_BITS-1:0]     w_rot_word;
    logic [sdcm_pkg::N_BITS-1:0]     w_rot_bit;
    logic [sdcm_pkg::RING_W-1:0]     w_coarse_pad;
    logic [sdcm_pkg::RING_W-1:0]     w_fine_pad;

    assign w_in_op    = sdcm_pkg::t_op'(i_op);
    assign w_accept   = start && (r_state == ST_IDLE);
    assign w_in_range = 32'(i_word_index) < sdcm_pkg::WORDS;
    assign w_load_en  = w_accept && (w_in_op == sdcm_pkg::OP_LOAD);
    assign w_load_word = (32'(i_word_index) == sdcm_pkg::WORDS - 1) ?
                         (i_data_word & sdcm_pkg::TOP_MASK) : i_data_word;

    // The ring turns toward bit zero: by one word or by one bit per step.
    assign w_ring       = w_flat[sdcm_pkg::N_BITS-1:0];
    assign w_rot_word   = {w_ring[sdcm_pkg::WORD_W-1:0], w_ring[sdcm_pkg::N_BITS-1:sdcm_pkg::WORD_W]};
    assign w_rot_bit    = {w_ring[0], w_ring[sdcm_pkg::N_BITS-1:1]};
    assign w_coarse_pad = sdcm_pkg::RING_W'(w_rot_word);
    assign w_fine_pad   = sdcm_pkg::RING_W'(w_rot_bit);

    genvar j;
    generate
        for (j = 0; j < sdcm_pkg::WORDS; j++) begin : g_cell
            assign w_flat[j*sdcm_pkg::WORD_W +: sdcm_pkg::WORD_W] = w_acc[j];
            sdcm_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_load        (w_load_en && (32'(i_word_index) == j)),
                .i_load_word   (w_load_word),
                .i_coarse_word (w_coarse_pad[j*sdcm_pkg::WORD_W +: sdcm_pkg::WORD_W]),
                .i_fine_word   (w_fine_pad[j*sdcm_pkg::WORD_W +: sdcm_pkg::WORD_W]),
                .o_acc         (w_acc[j])
            );
        end
    endgenerate

    assign w_wrap_dist = {1'b0, r_pos} + {1'b0, sdcm_pkg::RING_LEN} - {1'b0, r_off};

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_data   = r_data;
        n_pos    = r_pos;
        n_off    = r_off;
        n_rem    = r_rem;
        n_valid  = 1'b0;
        n_result = r_result;
        w_ctl    = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op   = w_in_op;
                    n_data = i_data_word;
                    n_pos  = sdcm_pkg::POS_W'({i_word_index, {sdcm_pkg::STEP_SHIFT{1'b0}}});
                    if (w_in_op == sdcm_pkg::OP_CLEAR) begin
                        w_ctl.clr = 1'b1;
                    end else if (w_in_range && (w_in_op == sdcm_pkg::OP_ACC)) begin
                        n_state = ST_SCAN;
                    end else if (w_in_range && (w_in_op == sdcm_pkg::OP_READ)) begin
                        n_state = ST_AIM;
                    end
                end
            end
            ST_SCAN: begin
                if (r_data == '0) begin
                    n_state = ST_IDLE;
                end else if (r_data[0] && (r_pos < sdcm_pkg::RING_LEN)) begin
                    n_state = ST_AIM;
                end else begin
                    n_data = r_data >> 1;
                    n_pos  = r_pos + sdcm_pkg::POS_W'(1);
                end
            end
            ST_AIM: begin
                if (r_pos >= r_off) begin
                    n_rem = r_pos - r_off;
                end else begin
                    n_rem = w_wrap_dist[sdcm_pkg::POS_W-1:0];
                end
                n_off   = r_pos;
                n_state = ST_MOVE;
            end
            ST_MOVE: begin
                if (r_rem[sdcm_pkg::POS_W-1:sdcm_pkg::STEP_SHIFT] != '0) begin
                    w_ctl.coarse = 1'b1;
                    n_rem = r_rem - sdcm_pkg::POS_W'(sdcm_pkg::WORD_W);
                end else if (r_rem != '0) begin
                    w_ctl.fine = 1'b1;
                    n_rem = r_rem - sdcm_pkg::POS_W'(1);
                end else if (r_op == sdcm_pkg::OP_READ) begin
                    n_valid  = 1'b1;
                    n_result = (r_pos == sdcm_pkg::TOP_POS) ?
                               (w_acc[0] & sdcm_pkg::TOP_MASK) : w_acc[0];
                    n_state  = ST_IDLE;
                end else begin
                    w_ctl.xor_en = 1'b1;
                    n_data  = r_data >> 1;
                    n_pos   = r_pos + sdcm_pkg::POS_W'(1);
                    n_state = ST_SCAN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_off   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_off   <= n_off;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_data   <= n_data;
        r_pos    <= n_pos;
        r_rem    <= n_rem;
        r_result <= n_result;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_result_word = r_result;

    a_valid_after_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_MOVE))
        else $error("Result strobe without a finished ring move.");

    a_offset_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off < sdcm_pkg::RING_LEN)
        else $error("Ring offset left the polynomial.");

    a_rem_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOVE) |-> (r_rem < sdcm_pkg::RING_LEN))
        else $error("Remaining ring distance out of range.");

    a_read_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == sdcm_pkg::OP_READ) && w_in_range) |=> busy)
        else $error("Accepted read did not start.");

endmodule
